@@ rtl/uam_pkg.sv @@
// Shared types and constants for the undirected adjacency matrix block.
`timescale 1ns / 1ps

package uam_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = 6;
  localparam int CNT_W        = 7;
  localparam int ROW_W        = 64;
  localparam int Q_DEPTH      = 2;
  localparam int QPTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] VCOUNT_RST = CNT_W'(MAX_VERTICES);

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_DEL  = 2'd1;
  localparam logic [1:0] FUNC_TEST = 2'd2;
  localparam logic [1:0] FUNC_LIST = 2'd3;

  typedef enum logic [2:0] {
    K_FAIL = 3'd0,
    K_ADD  = 3'd1,
    K_DEL  = 3'd2,
    K_TEST = 3'd3,
    K_LIST = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [VIDX_W-1:0] vertex_a;
    logic [VIDX_W-1:0] vertex_b;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic              edge_present;
    logic [VIDX_W-1:0] neighbour;
    logic              list_empty;
    logic              last;
  } out_t;

  typedef struct packed {
    kind_t             kind;
    logic [VIDX_W-1:0] va;
    logic [VIDX_W-1:0] vb;
    logic [CNT_W-1:0]  lim;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/uam_front.sv @@
// Front end: vertex count register, range check and command classification.
`timescale 1ns / 1ps

module uam_front
  import uam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_t              in_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  q_stat_t          q_stat,
  output logic             busy,
  output logic             push,
  output cmd_t             cmd
);

  logic [CNT_W-1:0] vcount_r;
  logic [CNT_W-1:0] lim;
  logic             a_ok;
  logic             b_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  assign lim  = (vcount_r > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_r;
  assign a_ok = {1'b0, in_data.vertex_a} < lim;
  assign b_ok = {1'b0, in_data.vertex_b} < lim;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    cmd.va   = in_data.vertex_a;
    cmd.vb   = in_data.vertex_b;
    cmd.lim  = lim;
    cmd.kind = K_FAIL;
    case (in_data.func)
      FUNC_ADD:  cmd.kind = (a_ok && b_ok) ? K_ADD  : K_FAIL;
      FUNC_DEL:  cmd.kind = (a_ok && b_ok) ? K_DEL  : K_FAIL;
      FUNC_TEST: cmd.kind = (a_ok && b_ok) ? K_TEST : K_FAIL;
      FUNC_LIST: cmd.kind = a_ok ? K_LIST : K_FAIL;
      default:   cmd.kind = K_FAIL;
    endcase
  end

endmodule

@@ rtl/uam_fifo.sv @@
// Short command queue between front end and back end.
`timescale 1ns / 1ps

module uam_fifo
  import uam_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t q_stat
);

  cmd_t              slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_cmd       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/uam_back.sv @@
// Back end: adjacency row memory, edge update, edge test and neighbor scan.
`timescale 1ns / 1ps

module uam_back
  import uam_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    q_cmd,
  input  q_stat_t q_stat,
  output logic    pop,
  output logic    out_valid,
  output out_t    out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WR2  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ROW_W-1:0]  scan_r, scan_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic [ROW_W-1:0]  row_vld_r;

  logic [ROW_W-1:0]  mem [MAX_VERTICES];
  logic [ROW_W-1:0]  rd_data_r;
  logic              rd_vld_r;

  logic              we;
  logic [VIDX_W-1:0] waddr;
  logic [VIDX_W-1:0] wbit;
  logic              wset;
  logic [ROW_W-1:0]  wmask;
  logic [ROW_W-1:0]  wdata;
  logic [ROW_W-1:0]  wonehot;
  logic              re;
  logic [VIDX_W-1:0] raddr;

  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  lim_mask;
  logic [VIDX_W-1:0] hi_idx;
  logic [ROW_W-1:0]  scan_rest;

  function automatic logic [VIDX_W-1:0] top_bit(input logic [ROW_W-1:0] v);
    logic [VIDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (v[i]) idx = VIDX_W'(i);
    end
    return idx;
  endfunction

  // A row never written reads as zero; its first write covers the whole row.
  assign row     = rd_vld_r ? rd_data_r : '0;
  assign wonehot = ROW_W'(1) << wbit;
  assign wmask   = row_vld_r[waddr] ? wonehot : '1;
  assign wdata   = wset ? wonehot : '0;

  always_comb begin
    for (int n = 0; n < ROW_W; n++) begin
      lim_mask[n] = CNT_W'(n) < cmd_r.lim;
    end
  end

  assign hi_idx    = top_bit(scan_r);
  assign scan_rest = scan_r & ~(ROW_W'(1) << hi_idx);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    scan_nxt      = scan_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = cmd_r.vb;
    wbit          = cmd_r.va;
    wset          = (cmd_r.kind == K_ADD);
    re            = 1'b0;
    raddr         = q_cmd.va;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            K_ADD, K_DEL: begin
              we        = 1'b1;
              waddr     = q_cmd.va;
              wbit      = q_cmd.vb;
              wset      = (q_cmd.kind == K_ADD);
              state_nxt = ST_WR2;
            end
            K_TEST, K_LIST: begin
              re        = 1'b1;
              state_nxt = ST_RD;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt.last  = 1'b1;
            end
          endcase
        end
      end
      ST_WR2: begin
        we            = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt.ok    = 1'b1;
        out_nxt.last  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RD: begin
        if (cmd_r.kind == K_LIST) begin
          scan_nxt  = row & lim_mask;
          state_nxt = ST_SCAN;
        end else begin
          out_valid_nxt        = 1'b1;
          out_nxt.ok           = 1'b1;
          out_nxt.edge_present = row[cmd_r.vb];
          out_nxt.last         = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_SCAN: begin
        out_valid_nxt = 1'b1;
        out_nxt.ok    = 1'b1;
        if (scan_r == '0) begin
          out_nxt.list_empty = 1'b1;
          out_nxt.last       = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          out_nxt.neighbour = hi_idx;
          out_nxt.last      = (scan_rest == '0);
          scan_nxt          = scan_rest;
          if (scan_rest == '0) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < ROW_W; i++) begin
        if (wmask[i]) mem[waddr][i] <= wdata[i];
      end
    end
    if (re) begin
      rd_data_r <= mem[raddr];
      rd_vld_r  <= row_vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) row_vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    scan_r <= scan_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/undirected_adjacency_matrix.sv @@
// Top level of the undirected graph adjacency matrix block.
//
// Use:
//   Input transaction: in_data {func, vertex_a, vertex_b} is taken at a rising
//   edge with start high and busy low. busy is high only while the two-entry
//   command queue is full.
//   Results: out_data {ok, edge_present, neighbour, list_empty, last} is shown
//   for exactly one cycle with out_valid high; there is no back-pressure.
//   Config: cfg_we/cfg_wdata writes vertex_count; write only while idle.
// Sequencing (per command once it reaches the back end, which owns the row memory
// with a single write port and a single registered read port):
//   invalid vertex     failure result, no memory access
//   add / remove       one bit write to row a, then one to row b
//   test               row read, then bit select
//   list neighbors     row read, then neighbor scan; an empty list gives one result
// Reset: clears the queue, the back-end state, all row valid bits (so every row
// reads as no edges) and sets vertex_count to 64. No clearing pass is needed.
// Neighbors come out in descending index order, one per cycle, last on the final.
`timescale 1ns / 1ps

module undirected_adjacency_matrix
  import uam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    front_cmd;
  cmd_t    head_cmd;

  // Front end: range check against the live vertex count, then classify.
  uam_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .cmd       (front_cmd)
  );

  // Decouples acceptance from the multi-cycle back end.
  uam_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .q_stat (q_stat)
  );

  // Back end: matrix storage and result generation.
  uam_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (head_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/uam_checker.sv @@
// Port-level checker for the adjacency matrix block, bound to the top level.
`timescale 1ns / 1ps

module uam_checker
  import uam_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_valid,
  input out_t             out_data
);

  // Reset leaves the queue empty and no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or out_valid after reset");

  // A failure is a lone, clean result.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |->
      out_data.last && !out_data.edge_present && !out_data.list_empty &&
      (out_data.neighbour == '0))
    else $error("malformed failure result");

  // Empty list results stand alone.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_empty |->
      out_data.last && out_data.ok && (out_data.neighbour == '0))
    else $error("malformed empty-list result");

  // A non-final result is a listed neighbor, followed at once by a lower one.
  a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=>
      out_valid && (out_data.neighbour < $past(out_data.neighbour)))
    else $error("neighbor listing broken or out of order");

  a_list_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.ok && !out_data.edge_present && !out_data.list_empty)
    else $error("non-final result is not a neighbor entry");

endmodule

bind undirected_adjacency_matrix uam_checker u_chk (.*);

@@ bench/undirected_adjacency_matrix_tb.sv @@
// Testbench for the undirected adjacency matrix block: directed and random graph traffic.
`timescale 1ns / 1ps

module undirected_adjacency_matrix_tb;
  import uam_pkg::*;

  // Watchdog limit, far above the length of a correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_data;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  undirected_adjacency_matrix i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the graph and of the vertex count register.
  logic [ROW_W-1:0] graph_rows [MAX_VERTICES];
  logic [CNT_W-1:0] vcount_shadow;

  // Results predicted at transaction accept time, oldest first.
  out_t pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;

  // Live vertex range: the count is clamped to the matrix size.
  function automatic int live_limit();
    return (int'(vcount_shadow) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_shadow);
  endfunction

  function automatic out_t result_word(logic ok, logic present, logic [VIDX_W-1:0] nb,
                                       logic empty, logic last);
    out_t r;
    r.ok           = ok;
    r.edge_present = present;
    r.neighbour    = nb;
    r.list_empty   = empty;
    r.last         = last;
    return r;
  endfunction

  // Apply one graph operation to the shadow matrix and queue the results it produces.
  function automatic void apply_graph_op(in_t item);
    int   lim;
    int   hits;
    out_t held;
    lim  = live_limit();
    hits = 0;
    held = '0;
    if (item.func == FUNC_LIST) begin
      if (int'(item.vertex_a) >= lim) begin
        pending_results.push_back(result_word(1'b0, 1'b0, '0, 1'b0, 1'b1));
        return;
      end
      // Descending scan over valid indices only; stale bits above the count stay hidden.
      for (int n = lim - 1; n >= 0; n--) begin
        if (graph_rows[item.vertex_a][n]) begin
          if (hits > 0) pending_results.push_back(held);
          held = result_word(1'b1, 1'b0, VIDX_W'(n), 1'b0, 1'b0);
          hits++;
        end
      end
      if (hits == 0) begin
        pending_results.push_back(result_word(1'b1, 1'b0, '0, 1'b1, 1'b1));
      end else begin
        held.last = 1'b1;
        pending_results.push_back(held);
      end
      return;
    end
    if (int'(item.vertex_a) >= lim || int'(item.vertex_b) >= lim) begin
      pending_results.push_back(result_word(1'b0, 1'b0, '0, 1'b0, 1'b1));
      return;
    end
    case (item.func)
      FUNC_ADD: begin
        graph_rows[item.vertex_a][item.vertex_b] = 1'b1;
        graph_rows[item.vertex_b][item.vertex_a] = 1'b1;
        pending_results.push_back(result_word(1'b1, 1'b0, '0, 1'b0, 1'b1));
      end
      FUNC_DEL: begin
        graph_rows[item.vertex_a][item.vertex_b] = 1'b0;
        graph_rows[item.vertex_b][item.vertex_a] = 1'b0;
        pending_results.push_back(result_word(1'b1, 1'b0, '0, 1'b0, 1'b1));
      end
      default: begin
        pending_results.push_back(result_word(1'b1, graph_rows[item.vertex_a][item.vertex_b],
                                              '0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  function automatic in_t make_op(logic [1:0] func, int a, int b);
    in_t item;
    item.func     = func;
    item.vertex_a = VIDX_W'(a);
    item.vertex_b = VIDX_W'(b);
    return item;
  endfunction

  // Pick a vertex: mostly valid, often from a small cluster so edges get hit again,
  // sometimes anywhere in the 6-bit range to reach the invalid path.
  function automatic int pick_vertex();
    int lim;
    int pick;
    lim  = live_limit();
    pick = $urandom_range(0, 9);
    if (lim == 0 || pick == 0) return $urandom_range(0, MAX_VERTICES - 1);
    if (pick < 5) return $urandom_range(0, ((lim < 8) ? lim : 8) - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  // Send one transaction: optional random gap, then hold start until busy is low at an edge.
  // start is left high after the accept so back-to-back items keep it high.
  task automatic send_op(in_t item);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    apply_graph_op(item);
  endtask

  // Lower start at the accept edge and wait for every queued result to arrive.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_vertex_count(int value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    vcount_shadow = CNT_W'(value);
    cfg_we <= 1'b0;
  endtask

  // Freshly reset graph: no edges anywhere, full vertex range.
  task automatic test_empty_graph();
    send_op(make_op(FUNC_LIST, 0, 0));
    send_op(make_op(FUNC_TEST, 63, 63));
    send_op(make_op(FUNC_LIST, 63, 17));
  endtask

  // Extreme indices, duplicate adds, self-loops, removing a missing edge.
  task automatic test_edge_ops();
    send_op(make_op(FUNC_ADD, 0, 63));
    send_op(make_op(FUNC_ADD, 63, 0));
    send_op(make_op(FUNC_ADD, 5, 5));
    send_op(make_op(FUNC_TEST, 0, 63));
    send_op(make_op(FUNC_TEST, 63, 0));
    send_op(make_op(FUNC_TEST, 5, 5));
    send_op(make_op(FUNC_LIST, 0, 0));
    send_op(make_op(FUNC_LIST, 5, 0));
    send_op(make_op(FUNC_LIST, 63, 0));
    send_op(make_op(FUNC_DEL, 63, 0));
    send_op(make_op(FUNC_TEST, 0, 63));
    send_op(make_op(FUNC_DEL, 0, 63));
    send_op(make_op(FUNC_LIST, 0, 0));
  endtask

  // Vertex count extremes: zero, tiny, saturated, and hiding/restoring stored edges.
  task automatic test_vertex_limit();
    write_vertex_count(0);
    send_op(make_op(FUNC_ADD, 0, 0));
    send_op(make_op(FUNC_LIST, 0, 0));
    write_vertex_count(2);
    send_op(make_op(FUNC_ADD, 1, 1));
    send_op(make_op(FUNC_ADD, 1, 2));
    send_op(make_op(FUNC_TEST, 2, 0));
    send_op(make_op(FUNC_LIST, 1, 63));   // vertex_b ignored on listing
    write_vertex_count(127);
    send_op(make_op(FUNC_ADD, 1, 63));
    write_vertex_count(8);
    send_op(make_op(FUNC_LIST, 1, 0));    // edge to 63 stored but out of range
    write_vertex_count(64);
    send_op(make_op(FUNC_LIST, 1, 0));
  endtask

  // One vertex joined to every vertex, then listed: the longest possible burst.
  task automatic test_full_row();
    int hub;
    int first;
    hub   = $urandom_range(0, MAX_VERTICES - 1);
    first = $urandom_range(0, MAX_VERTICES - 1);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      send_op(make_op(FUNC_ADD, hub, (first + i) % MAX_VERTICES));
    end
    send_op(make_op(FUNC_LIST, hub, $urandom_range(0, 63)));
    repeat (4) send_op(make_op(FUNC_DEL, hub, $urandom_range(0, 63)));
    send_op(make_op(FUNC_LIST, hub, 0));
  endtask

  // Random mix weighted toward valid vertices so tests and listings find edges.
  task automatic test_random_traffic(int n_ops);
    for (int i = 0; i < n_ops; i++) begin
      send_op(make_op(2'($urandom_range(0, 3)), pick_vertex(), pick_vertex()));
    end
  endtask

  function automatic void check_field(string field, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
      error_count++;
    end
  endfunction

  // Result monitor: every strobe is compared against the oldest prediction.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("ok", 32'(exp_r.ok), 32'(out_data.ok));
        check_field("edge_present", 32'(exp_r.edge_present), 32'(out_data.edge_present));
        check_field("neighbour", 32'(exp_r.neighbour), 32'(out_data.neighbour));
        check_field("list_empty", 32'(exp_r.list_empty), 32'(out_data.list_empty));
        check_field("last", 32'(exp_r.last), 32'(out_data.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    for (int r = 0; r < MAX_VERTICES; r++) graph_rows[r] = '0;
    vcount_shadow = VCOUNT_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender puts a random gap before 38% of items through the directed part and the first random phase.
    sender_idle_pct = 38;
    test_empty_graph();
    test_edge_ops();
    test_vertex_limit();
    test_full_row();
    test_random_traffic(20);

    // Gap before 53% of items, reduced random vertex range.
    write_vertex_count($urandom_range(1, 63));
    sender_idle_pct = 53;
    test_random_traffic(60);

    // Back to back, count written above the matrix size so the range is clamped to the full matrix.
    write_vertex_count(127);
    sender_idle_pct = 0;
    test_random_traffic(60);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
